// ===== rtl/slxfp_pkg.sv =====
// Package for the sync/length/XOR frame parser.
// Holds the register map, the reset values, the result codes and the shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slxfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register map
    localparam t_cfg_idx REG_SYNC_FIRST    = 3'd0;
    localparam t_cfg_idx REG_SYNC_SECOND   = 3'd1;
    localparam t_cfg_idx REG_SYNC_THIRD    = 3'd2;
    localparam t_cfg_idx REG_IDENT_LOWEST  = 3'd3;
    localparam t_cfg_idx REG_IDENT_HIGHEST = 3'd4;

    localparam t_byte RST_SYNC_FIRST    = 8'h00;
    localparam t_byte RST_SYNC_SECOND   = 8'hF9;
    localparam t_byte RST_SYNC_THIRD    = 8'h06;
    localparam t_byte RST_IDENT_LOWEST  = 8'h50;
    localparam t_byte RST_IDENT_HIGHEST = 8'h53;

    // result kinds
    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_GOOD    = 2'd1;
    localparam t_kind KIND_BAD     = 2'd2;

    typedef struct packed {
        t_byte sync_first;
        t_byte sync_second;
        t_byte sync_third;
        t_byte ident_lowest;
        t_byte ident_highest;
    } t_cfg;

    typedef struct packed {
        t_kind out_kind;
        t_byte frame_ident;
        t_byte data_byte;
        t_byte byte_index;
        t_byte frame_length;
        t_byte computed_check;
        t_byte received_check;
        logic  last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/slxfp_stream_if.sv =====
// Valid/ready channel interfaces: received bytes in, parser results out.
// Depends on slxfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface slxfp_byte_if;
    import slxfp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface slxfp_result_if;
    import slxfp_pkg::*;

    logic    valid;
    logic    ready;
    t_result result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== rtl/slxfp_cfg_regs.sv =====
// Configuration register file: sync bytes and identifier range.
// Depends on slxfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slxfp_cfg_regs (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  slxfp_pkg::t_cfg_idx  i_cfg_idx,
    input  slxfp_pkg::t_byte     i_cfg_data,
    output slxfp_pkg::t_cfg      o_cfg
);
    import slxfp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= RST_SYNC_FIRST;
            r_cfg.sync_second   <= RST_SYNC_SECOND;
            r_cfg.sync_third    <= RST_SYNC_THIRD;
            r_cfg.ident_lowest  <= RST_IDENT_LOWEST;
            r_cfg.ident_highest <= RST_IDENT_HIGHEST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYNC_FIRST:    r_cfg.sync_first    <= i_cfg_data;
                REG_SYNC_SECOND:   r_cfg.sync_second   <= i_cfg_data;
                REG_SYNC_THIRD:    r_cfg.sync_third    <= i_cfg_data;
                REG_IDENT_LOWEST:  r_cfg.ident_lowest  <= i_cfg_data;
                REG_IDENT_HIGHEST: r_cfg.ident_highest <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/slxfp_core.sv =====
// Parser state machine: sync window search, frame field tracking, XOR check.
// Produces at most one result per accepted byte, combinationally from state and the input byte.
// Depends on slxfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slxfp_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  slxfp_pkg::t_byte    i_byte,
    input  slxfp_pkg::t_cfg     i_cfg,
    output logic                o_res_valid,
    output slxfp_pkg::t_result  o_res
);
    import slxfp_pkg::*;

    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_EXTRA1  = 3'd1;
    localparam logic [2:0] PH_EXTRA2  = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    localparam logic [1:0] FILL_FULL = 2'd3;

    logic [2:0] r_phase, n_phase;
    t_byte      r_win0, r_win1, r_win2, n_win0, n_win1, n_win2;
    logic [1:0] r_fill, n_fill;
    t_byte      r_ident, n_ident;
    t_byte      r_len, n_len;
    t_byte      r_count, n_count;
    t_byte      r_xor, n_xor;

    logic  hit;
    t_byte count_inc;

    assign hit = (r_fill == FILL_FULL)
              && (r_win0 == i_cfg.sync_first)
              && (r_win1 == i_cfg.sync_second)
              && (r_win2 == i_cfg.sync_third)
              && (i_byte >= i_cfg.ident_lowest)
              && (i_byte <= i_cfg.ident_highest);

    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_win0  = r_win0;
        n_win1  = r_win1;
        n_win2  = r_win2;
        n_fill  = r_fill;
        n_ident = r_ident;
        n_len   = r_len;
        n_count = r_count;
        n_xor   = r_xor;

        o_res_valid          = 1'b0;
        o_res.out_kind       = KIND_PAYLOAD;
        o_res.frame_ident    = r_ident;
        o_res.data_byte      = '0;
        o_res.byte_index     = '0;
        o_res.frame_length   = r_len;
        o_res.computed_check = '0;
        o_res.received_check = '0;
        o_res.last           = 1'b0;

        case (r_phase)
            PH_EXTRA1: begin
                n_xor   = r_xor ^ i_byte;
                n_phase = PH_EXTRA2;
            end
            PH_EXTRA2: begin
                n_xor   = r_xor ^ i_byte;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_xor   = r_xor ^ i_byte;
                n_len   = i_byte;
                n_count = '0;
                n_phase = (i_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_xor            = r_xor ^ i_byte;
                n_count          = count_inc;
                o_res_valid      = 1'b1;
                o_res.data_byte  = i_byte;
                o_res.byte_index = r_count;
                if (count_inc == r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_res_valid          = 1'b1;
                o_res.out_kind       = (r_xor == i_byte) ? KIND_GOOD : KIND_BAD;
                o_res.computed_check = r_xor;
                o_res.received_check = i_byte;
                o_res.last           = 1'b1;
                n_phase = PH_SEARCH;
                n_win0  = '0;
                n_win1  = '0;
                n_win2  = '0;
                n_fill  = '0;
            end
            default: begin
                if (hit) begin
                    n_ident = i_byte;
                    n_len   = '0;
                    n_count = '0;
                    n_xor   = i_byte;
                    n_win0  = '0;
                    n_win1  = '0;
                    n_win2  = '0;
                    n_fill  = '0;
                    n_phase = PH_EXTRA1;
                end else begin
                    n_win0  = r_win1;
                    n_win1  = r_win2;
                    n_win2  = i_byte;
                    if (r_fill != FILL_FULL) begin
                        n_fill = r_fill + 2'd1;
                    end
                    n_phase = PH_SEARCH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_win0  <= '0;
            r_win1  <= '0;
            r_win2  <= '0;
            r_fill  <= '0;
            r_ident <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_xor   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_win0  <= n_win0;
            r_win1  <= n_win1;
            r_win2  <= n_win2;
            r_fill  <= n_fill;
            r_ident <= n_ident;
            r_len   <= n_len;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slxfp_out_reg.sv =====
// Result register: holds one result until the receiver takes it.
// Input side may load a new result in the same cycle the held one leaves.
// Depends on slxfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slxfp_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire                 i_res_valid,
    input  slxfp_pkg::t_result  i_res,
    output logic                o_in_ready,
    output logic                o_valid,
    output slxfp_pkg::t_result  o_result,
    input  wire                 i_out_ready
);
    import slxfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_accept && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_res_valid) begin
            r_result <= i_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/sync_length_xor_frame_parser.sv =====
// Top level of the sync/length/XOR frame parser.
// Depends on slxfp_pkg, slxfp_stream_if, slxfp_cfg_regs, slxfp_core, slxfp_out_reg.
//
// Usage:
//   i_byte   : one received byte per transaction (valid/ready).
//   o_result : payload items and one end item per frame, marked last, with
//              good/checksum-error kind, computed and received check.
//   i_cfg_*  : register writes (sync bytes, identifier range), one per cycle
//              with i_cfg_we high; only while the parser is idle.
// Results: a result is registered and appears on o_result in the cycle after
//   the byte that causes it is accepted. Header, extra and length bytes give no result.
// Throughput: one byte per cycle unless a held result stalls; the state update is a
//   compare, an XOR and an 8-bit count, all done in the accepting cycle.
// Stall: while a held result is not taken, i_byte.ready is low; it rises in
//   the cycle the receiver takes the result, so no bubble is added.
// Reset (i_rst_n low, synchronous): registers return to their defaults,
//   the parser searches with an empty window, the result register empties.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_xor_frame_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    slxfp_byte_if.sink          i_byte,
    slxfp_result_if.source      o_result,
    input  wire                 i_cfg_we,
    input  slxfp_pkg::t_cfg_idx i_cfg_idx,
    input  slxfp_pkg::t_byte    i_cfg_data
);
    import slxfp_pkg::*;

    t_cfg    cfg;
    logic    accept;
    logic    in_ready;
    logic    res_valid;
    t_result res;

    assign i_byte.ready = in_ready;
    assign accept       = i_byte.valid && in_ready;

    slxfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    slxfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_byte.byte_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    slxfp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (in_ready),
        .o_valid     (o_result.valid),
        .o_result    (o_result.result),
        .i_out_ready (o_result.ready)
    );

endmodule

`default_nettype wire

// ===== tb/sync_length_xor_frame_parser_test.sv =====
// Testbench for sync_length_xor_frame_parser: directed and random byte streams with
// a byte-level model of the sync search, frame walk and XOR check; results are scoreboarded.
// Depends on slxfp_pkg, slxfp_stream_if and the parser RTL.
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_test;
    import slxfp_pkg::*;

    localparam int RANDOM_BYTES   = 400;
    localparam int PHASE_BYTES    = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam t_cfg_idx REG_FIRST_UNUSED = REG_IDENT_HIGHEST + 3'd1;

    typedef enum logic [2:0] {
        SCAN, EXTRA_ONE, EXTRA_TWO, LEN_BYTE, PAYLOAD, CHECK_BYTE
    } t_scan_phase;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_byte    i_cfg_data;

    slxfp_byte_if   byte_ch ();
    slxfp_result_if result_ch ();

    sync_length_xor_frame_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser model state
    t_cfg        cfg_model;
    t_byte       win [3];
    int          win_fill;
    t_scan_phase scan_phase;
    t_byte       held_ident;
    t_byte       held_len;
    t_byte       pay_cnt;
    t_byte       run_xor;

    t_result expected_items [$];
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      idle_cycles = 0;
    int      stall_left = 0;
    bit      gaps_on = 1'b1;
    bit      stalls_on = 1'b1;

    task automatic clear_window;
        win[0] = '0;
        win[1] = '0;
        win[2] = '0;
        win_fill = 0;
    endtask

    task automatic model_reset;
        cfg_model.sync_first    = RST_SYNC_FIRST;
        cfg_model.sync_second   = RST_SYNC_SECOND;
        cfg_model.sync_third    = RST_SYNC_THIRD;
        cfg_model.ident_lowest  = RST_IDENT_LOWEST;
        cfg_model.ident_highest = RST_IDENT_HIGHEST;
        clear_window();
        scan_phase = SCAN;
        held_ident = '0;
        held_len   = '0;
        pay_cnt    = '0;
        run_xor    = '0;
    endtask

    // one accepted byte through the model; queues the result it causes, if any
    task automatic model_parse_byte(input t_byte b);
        t_result item;
        logic    hit;
        item = '0;
        case (scan_phase)
            EXTRA_ONE: begin
                run_xor ^= b;
                scan_phase = EXTRA_TWO;
            end
            EXTRA_TWO: begin
                run_xor ^= b;
                scan_phase = LEN_BYTE;
            end
            LEN_BYTE: begin
                run_xor ^= b;
                held_len = b;
                pay_cnt = '0;
                scan_phase = (b == 8'd0) ? CHECK_BYTE : PAYLOAD;
            end
            PAYLOAD: begin
                run_xor ^= b;
                item.out_kind     = KIND_PAYLOAD;
                item.frame_ident  = held_ident;
                item.data_byte    = b;
                item.byte_index   = pay_cnt;
                item.frame_length = held_len;
                expected_items.push_back(item);
                pay_cnt = pay_cnt + 8'd1;
                if (pay_cnt == held_len) scan_phase = CHECK_BYTE;
            end
            CHECK_BYTE: begin
                item.out_kind       = (run_xor == b) ? KIND_GOOD : KIND_BAD;
                item.frame_ident    = held_ident;
                item.frame_length   = held_len;
                item.computed_check = run_xor;
                item.received_check = b;
                item.last           = 1'b1;
                expected_items.push_back(item);
                scan_phase = SCAN;
                clear_window();
            end
            default: begin
                hit = (win_fill >= 3) && (win[0] == cfg_model.sync_first) &&
                      (win[1] == cfg_model.sync_second) && (win[2] == cfg_model.sync_third) &&
                      (b >= cfg_model.ident_lowest) && (b <= cfg_model.ident_highest);
                if (hit) begin
                    held_ident = b;
                    held_len   = '0;
                    pay_cnt    = '0;
                    run_xor    = b;
                    clear_window();
                    scan_phase = EXTRA_ONE;
                end else begin
                    win[0] = win[1];
                    win[1] = win[2];
                    win[2] = b;
                    if (win_fill < 3) win_fill++;
                end
            end
        endcase
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_byte(input t_byte b);
        if (gaps_on && $urandom_range(0, 99) < 2) begin
            byte_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        byte_ch.valid   = 1'b1;
        byte_ch.byte_in = b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        model_parse_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_sync;
        send_byte(cfg_model.sync_first);
        send_byte(cfg_model.sync_second);
        send_byte(cfg_model.sync_third);
    endtask

    // full frame with the current sync bytes and random payload
    task automatic send_frame(input t_byte ident, input t_byte e1, input t_byte e2,
                              input int len, input bit corrupt);
        t_byte chk;
        t_byte pb;
        chk = ident ^ e1 ^ e2 ^ t_byte'(len);
        send_sync();
        send_byte(ident);
        send_byte(e1);
        send_byte(e2);
        send_byte(t_byte'(len));
        for (int k = 0; k < len; k++) begin
            pb = t_byte'($urandom);
            chk ^= pb;
            send_byte(pb);
        end
        if (corrupt) chk ^= t_byte'(8'd1 << $urandom_range(0, 7));
        send_byte(chk);
    endtask

    // sender stops and waits out every outstanding transaction
    task automatic wait_drained;
        byte_ch.valid = 1'b0;
        while (expected_items.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        case (idx)
            REG_SYNC_FIRST:    cfg_model.sync_first    = val;
            REG_SYNC_SECOND:   cfg_model.sync_second   = val;
            REG_SYNC_THIRD:    cfg_model.sync_third    = val;
            REG_IDENT_LOWEST:  cfg_model.ident_lowest  = val;
            REG_IDENT_HIGHEST: cfg_model.ident_highest = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input t_byte s1, input t_byte s2, input t_byte s3,
                             input t_byte lo, input t_byte hi);
        write_reg(REG_SYNC_FIRST, s1);
        write_reg(REG_SYNC_SECOND, s2);
        write_reg(REG_SYNC_THIRD, s3);
        write_reg(REG_IDENT_LOWEST, lo);
        write_reg(REG_IDENT_HIGHEST, hi);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ---------------- result receiver ----------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ch.ready = 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 2) begin
            stall_left = $urandom_range(0, 3);
            result_ch.ready = 1'b0;
        end else begin
            result_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.result;
            if (expected_items.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_items.pop_front();
                compare_field("out_kind", want.out_kind, got.out_kind);
                compare_field("frame_ident", want.frame_ident, got.frame_ident);
                compare_field("data_byte", want.data_byte, got.data_byte);
                compare_field("byte_index", want.byte_index, got.byte_index);
                compare_field("frame_length", want.frame_length, got.frame_length);
                compare_field("computed_check", want.computed_check, got.computed_check);
                compare_field("received_check", want.received_check, got.received_check);
                compare_field("last", want.last, got.last);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    // straight out of reset only two real bytes are in the window
    task automatic test_window_fill;
        send_byte(RST_SYNC_SECOND);
        send_byte(RST_SYNC_THIRD);
        send_byte(RST_IDENT_LOWEST);
    endtask

    task automatic test_good_frame;
        send_frame(RST_IDENT_LOWEST, 8'h00, 8'hFF, 2, 1'b0);
    endtask

    // window is cleared at frame end, so a trailing partial header cannot match
    task automatic test_window_cleared;
        send_byte(RST_SYNC_SECOND);
        send_byte(RST_SYNC_THIRD);
        send_byte(RST_IDENT_LOWEST + 8'd1);
        send_frame(RST_IDENT_HIGHEST, 8'hFF, 8'h00, 0, 1'b1);
    endtask

    task automatic test_ident_bounds;
        send_sync();
        send_byte(RST_IDENT_LOWEST - 8'd1);
        send_sync();
        send_byte(RST_IDENT_HIGHEST + 8'd1);
    endtask

    task automatic test_config_extremes;
        wait_drained();
        write_all(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        send_frame(8'h00, 8'h5A, 8'hA5, 1, 1'b0);
        wait_drained();
        write_reg(REG_IDENT_LOWEST, 8'hFF);
        send_frame(8'hFF, 8'hFF, 8'hFF, 1, 1'b0);
        wait_drained();
        // lowest above highest: nothing may match
        write_all(8'h00, 8'h00, 8'h00, 8'h80, 8'h7F);
        send_sync();
        send_byte(8'h80);
        send_sync();
        send_byte(8'h7F);
    endtask

    task automatic test_write_mid_frame;
        wait_drained();
        write_all(8'h11, 8'h22, 8'h33, 8'h10, 8'h20);
        send_sync();
        send_byte(8'h18);
        send_byte(8'hA5);
        send_byte(8'h5A);
        wait_drained();
        write_reg(REG_IDENT_LOWEST, 8'hF0);
        write_reg(REG_SYNC_FIRST, 8'h99);
        send_byte(8'h01);
        send_byte(8'h3C);
        send_byte(8'h18 ^ 8'hA5 ^ 8'h5A ^ 8'h01 ^ 8'h3C);
        send_sync();
        send_byte(8'h18);
    endtask

    task automatic test_unused_index;
        wait_drained();
        write_reg(REG_IDENT_LOWEST, 8'h10);
        for (int k = 0; k < 3; k++) write_reg(t_cfg_idx'(REG_FIRST_UNUSED + k), 8'h00);
        send_frame(8'h20, 8'h01, 8'h80, 3, 1'b0);
    endtask

    task automatic test_random_traffic;
        int    start_count;
        int    phase_start;
        int    choice;
        int    len;
        int    pos;
        bit    big_sent;
        t_byte lo;
        t_byte hi;
        t_byte id;
        start_count = bytes_sent;
        big_sent = 1'b0;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            wait_drained();
            choice = $urandom_range(0, 5);
            case (choice)
                0: write_all(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_SYNC_THIRD,
                             RST_IDENT_LOWEST, RST_IDENT_HIGHEST);
                1: begin
                    lo = t_byte'($urandom);
                    hi = t_byte'($urandom_range(lo, 255));
                    write_all(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom), lo, hi);
                end
                2: write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
                3: write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                4: begin
                    lo = t_byte'($urandom_range(1, 255));
                    hi = t_byte'($urandom_range(0, lo - 1));
                    write_all(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom), lo, hi);
                end
                default: begin
                    lo = t_byte'($urandom);
                    write_all(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom), lo, lo);
                end
            endcase
            lo = cfg_model.ident_lowest;
            hi = cfg_model.ident_highest;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                pos = bytes_sent - start_count;
                gaps_on   = !(pos >= 150 && pos < 300);
                stalls_on = gaps_on;
                id = (lo <= hi) ? t_byte'($urandom_range(lo, hi)) : t_byte'($urandom);
                choice = $urandom_range(0, 99);
                if (choice < 70) begin
                    repeat ($urandom_range(0, 2)) send_byte(t_byte'($urandom));
                    if (!big_sent && pos > 50 && lo <= hi && scan_phase == SCAN) begin
                        len = 255;
                        big_sent = 1'b1;
                    end else if ($urandom_range(0, 99) < 10) begin
                        len = $urandom_range(7, 32);
                    end else begin
                        len = $urandom_range(0, 6);
                    end
                    send_frame(id, t_byte'($urandom), t_byte'($urandom), len,
                               $urandom_range(0, 99) < 25);
                end else if (choice < 85) begin
                    repeat ($urandom_range(1, 5)) send_byte(t_byte'($urandom));
                end else if (choice < 92) begin
                    // partial header, then a stray byte
                    send_byte(cfg_model.sync_first);
                    if ($urandom_range(0, 1)) send_byte(cfg_model.sync_second);
                    send_byte(t_byte'($urandom));
                end else if (choice < 96) begin
                    // identifier just outside the range
                    send_sync();
                    if (hi < 8'hFF) send_byte(hi + 8'd1);
                    else if (lo > 8'h00) send_byte(lo - 8'd1);
                    else send_byte(t_byte'($urandom));
                end else begin
                    // header with a length longer than what follows
                    send_sync();
                    send_byte(id);
                    send_byte(t_byte'($urandom));
                    send_byte(t_byte'($urandom));
                    send_byte(t_byte'($urandom_range(4, 12)));
                    repeat ($urandom_range(0, 3)) send_byte(t_byte'($urandom));
                end
                if ($urandom_range(0, 49) == 0) wait_drained();
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_SYNC_FIRST;
        i_cfg_data      = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = '0;
        result_ch.ready = 1'b0;
        model_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_window_fill();
        test_good_frame();
        test_window_cleared();
        test_ident_bounds();
        test_config_extremes();
        test_write_mid_frame();
        test_unused_index();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_items.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
